>>> rtl/csbi_pkg.sv
package csbi_pkg;

  localparam int MAX_ITEMS_DEF   = 1024;
  localparam int MAX_BUCKETS_DEF = 256;

  localparam int KEY_W       = 16;
  localparam int CMD_W       = 2;
  localparam int ADDR_W      = 11;
  localparam int VAL_W       = 11;
  localparam int STAT_W      = 2;
  localparam int CFG_IDX_W   = 1;
  localparam int RS_W        = 18;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 16;

  localparam logic [CMD_W-1:0] CMD_LOAD      = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RD_PREFIX = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RD_SORTED = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD_ADDR   = 2'd1;
  localparam logic [STAT_W-1:0] ST_OVERFLOW   = 2'd2;
  localparam logic [STAT_W-1:0] ST_RANGE_WIDE = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_MIN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_MAX = 1'b1;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_EXEC, S_LD_WR, S_PFX0, S_PFX_RD, S_PFX_WR,
    S_SC_RDK, S_SC_RDC, S_SC_WR, S_RD_WAIT, S_DONE
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_CLR, OP_ACCEPT, OP_LOAD, OP_READ, OP_LD_WR, OP_PFX_INIT,
    OP_PFX_RD, OP_PFX_WR, OP_SC_RDK, OP_SC_RDC, OP_SC_WR, OP_RD_CAP, OP_DONE
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             in_fire;
    logic             last;
    logic             ld_wide;
    logic             ld_inc;
    logic             pfx_done;
    logic             scat_done;
    logic             clr_done;
    logic             out_free;
    logic             clear_pending;
  } dp_stat_t;

endpackage

>>> rtl/counting_sort_bucket_index_top.sv
// counting sort bucket index
//
// s_* channel takes one command item per handshake (s_tvalid & s_tready):
// load a key, read a prefix entry or read a sorted position. s_tlast on a
// load closes the batch and starts the index build. m_* channel returns
// exactly one result item per command: read data or kept count, and status.
// key_min / key_max are written through cfg_we / cfg_index / cfg_data and
// select which keys get a bucket. the user must write them only while the
// block is idle; the block itself does not enforce it.
//
// steps per item, one item in flight at a time:
//   read commands   address check, ram read, result capture
//   plain load      bucket count read-modify-write in ram
//   closing load    adds a prefix pass over the buckets of the range and
//                   a scatter pass over the loaded items
// after reset, a build or a discarded batch, the bucket count ram is
// cleared one entry a cycle, s_tready low, before the next item is taken.
// the result sits in an output register; while m_tready is low the block
// still takes the next item and works on it, holding only at the hand-off.
module counting_sort_bucket_index_top import csbi_pkg::*; #(
  parameter int MAX_ITEMS   = MAX_ITEMS_DEF,
  parameter int MAX_BUCKETS = MAX_BUCKETS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // command[1:0], key[17:2], address[28:18]
  input  logic                   s_tlast,   // is_last
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // value[10:0], status[12:11]
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [KEY_W-1:0]       cfg_data
);

  dp_cmd_t           cmd;
  dp_stat_t          stat;
  logic [VAL_W-1:0]  out_value;
  logic [STAT_W-1:0] out_status;

  // sequencer: load, prefix pass, scatter, read and clearing steps
  csbi_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  // counters, config registers and the five rams
  csbi_dp #(
    .MAX_ITEMS   (MAX_ITEMS),
    .MAX_BUCKETS (MAX_BUCKETS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_command (s_tdata[1:0]),
    .in_key     (s_tdata[17:2]),
    .in_last    (s_tlast),
    .in_address (s_tdata[28:18]),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_value  (out_value),
    .out_status (out_status),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // pack result, upper bits zero
  assign m_tdata = {{(OUT_TDATA_W - VAL_W - STAT_W){1'b0}}, out_status, out_value};

endmodule

>>> rtl/csbi_ram.sv
module csbi_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/csbi_ctrl.sv
module csbi_ctrl import csbi_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLR:     if (stat.clr_done) state_next = S_IDLE;
      S_IDLE:    if (stat.in_fire) state_next = S_EXEC;
      S_EXEC: begin
        priority if (stat.cmd != CMD_LOAD) state_next = S_RD_WAIT;
        else if (stat.ld_wide)             state_next = S_DONE;
        else if (stat.ld_inc)              state_next = S_LD_WR;
        else if (stat.last)                state_next = S_PFX0;
        else                               state_next = S_DONE;
      end
      S_LD_WR:   state_next = stat.last ? S_PFX0 : S_DONE;
      S_PFX0:    state_next = S_PFX_RD;
      S_PFX_RD:  state_next = stat.pfx_done ? S_SC_RDK : S_PFX_WR;
      S_PFX_WR:  state_next = S_PFX_RD;
      S_SC_RDK:  state_next = stat.scat_done ? S_DONE : S_SC_RDC;
      S_SC_RDC:  state_next = S_SC_WR;
      S_SC_WR:   state_next = S_SC_RDK;
      S_RD_WAIT: state_next = S_DONE;
      S_DONE: begin
        if (stat.out_free) state_next = stat.clear_pending ? S_CLR : S_IDLE;
      end
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.op = OP_NONE;
    unique case (state)
      S_CLR:     cmd.op = OP_CLR;
      S_IDLE:    cmd.op = OP_ACCEPT;
      S_EXEC:    cmd.op = (stat.cmd == CMD_LOAD) ? OP_LOAD : OP_READ;
      S_LD_WR:   cmd.op = OP_LD_WR;
      S_PFX0:    cmd.op = OP_PFX_INIT;
      S_PFX_RD:  cmd.op = OP_PFX_RD;
      S_PFX_WR:  cmd.op = OP_PFX_WR;
      S_SC_RDK:  cmd.op = OP_SC_RDK;
      S_SC_RDC:  cmd.op = OP_SC_RDC;
      S_SC_WR:   cmd.op = OP_SC_WR;
      S_RD_WAIT: cmd.op = OP_RD_CAP;
      S_DONE:    cmd.op = OP_DONE;
      default:   cmd.op = OP_NONE;
    endcase
  end

endmodule

>>> rtl/csbi_dp.sv
module csbi_dp import csbi_pkg::*; #(
  parameter int MAX_ITEMS   = MAX_ITEMS_DEF,
  parameter int MAX_BUCKETS = MAX_BUCKETS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  dp_cmd_t                     cmd,
  output dp_stat_t                    stat,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [CMD_W-1:0]            in_command,
  input  logic signed [KEY_W-1:0]     in_key,
  input  logic                        in_last,
  input  logic [ADDR_W-1:0]           in_address,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [VAL_W-1:0]            out_value,
  output logic [STAT_W-1:0]           out_status,
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [KEY_W-1:0]            cfg_data
);

  localparam int IW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int RW = CW + 1;
  localparam int BW = $clog2(MAX_BUCKETS);
  localparam int PW = $clog2(MAX_BUCKETS + 1);

  logic signed [KEY_W-1:0] key_min, key_max;
  logic [CMD_W-1:0]        cmd_r;
  logic signed [KEY_W-1:0] key_r;
  logic                    last_r;
  logic [ADDR_W-1:0]       addr_r;
  logic [CW-1:0]           item_count;
  logic                    built;
  logic [PW-1:0]           built_buckets;
  logic [CW-1:0]           total;
  logic [PW-1:0]           idx;
  logic [CW-1:0]           j;
  logic [CW-1:0]           acc;
  logic [BW-1:0]           off_r;
  logic                    rng_r;
  logic                    rd_ok_r;
  logic [VAL_W-1:0]        res_value;
  logic [STAT_W-1:0]       res_status;
  logic                    clear_pending;

  logic signed [RS_W-1:0]  rs_cur;
  logic                    range_wide;
  logic [PW-1:0]           n_cur;
  logic [CW-1:0]           ic_eff;
  logic                    key_in_rng, ld_store, ld_inc;
  logic [BW-1:0]           key_off;
  logic signed [KEY_W-1:0] key_rd;
  logic                    sc_in_rng;
  logic [BW-1:0]           sc_off;
  logic [CW-1:0]           cnt_rd;
  logic [CW-1:0]           pfx_rd;
  logic [RW-1:0]           cur_rd;
  logic [IW-1:0]           srt_rd;
  logic                    pos_ok, rd_ok, out_free;

  logic          key_we;
  logic [IW-1:0] key_waddr;
  logic          cnt_we;
  logic [BW-1:0] cnt_waddr, cnt_raddr;
  logic [CW-1:0] cnt_wdata;
  logic          pfx_we;
  logic [PW-1:0] pfx_waddr;
  logic [CW-1:0] pfx_wdata;
  logic          cur_we;
  logic [BW-1:0] cur_waddr;
  logic [RW-1:0] cur_wdata;
  logic          srt_we;

  assign rs_cur     = RS_W'(key_max) - RS_W'(key_min) + RS_W'(1);
  assign range_wide = rs_cur > $signed(RS_W'(MAX_BUCKETS));
  assign n_cur      = (rs_cur[RS_W-1] || rs_cur == '0) ? '0 : PW'(rs_cur);
  assign ic_eff     = built ? '0 : item_count;
  assign key_in_rng = (key_r >= key_min) && (key_r <= key_max);
  assign ld_store   = !range_wide && (32'(ic_eff) < MAX_ITEMS);
  assign ld_inc     = ld_store && key_in_rng;
  assign key_off    = BW'(RS_W'(key_r) - RS_W'(key_min));
  assign sc_in_rng  = (key_rd >= key_min) && (key_rd <= key_max);
  assign sc_off     = BW'(RS_W'(key_rd) - RS_W'(key_min));
  assign pos_ok     = 32'(cur_rd) < MAX_ITEMS;
  assign out_free   = !out_valid || out_ready;
  assign in_ready   = (cmd.op == OP_ACCEPT);

  always_comb begin
    unique case (cmd_r)
      CMD_RD_PREFIX: rd_ok = built && (32'(addr_r) <= 32'(built_buckets));
      CMD_RD_SORTED: rd_ok = built && (32'(addr_r) < 32'(total))
                             && (32'(addr_r) < MAX_ITEMS);
      default:       rd_ok = 1'b0;
    endcase
  end

  always_comb begin
    stat.cmd           = cmd_r;
    stat.in_fire       = in_valid && in_ready;
    stat.last          = last_r;
    stat.ld_wide       = range_wide;
    stat.ld_inc        = ld_inc;
    stat.pfx_done      = (idx == built_buckets);
    stat.scat_done     = (j == item_count);
    stat.clr_done      = (idx == PW'(MAX_BUCKETS - 1));
    stat.out_free      = out_free;
    stat.clear_pending = clear_pending;
  end

  // memory port steering
  always_comb begin
    key_we    = (cmd.op == OP_LOAD) && ld_store;
    key_waddr = IW'(ic_eff);
    cnt_we    = 1'b0;
    cnt_waddr = off_r;
    cnt_wdata = cnt_rd + CW'(1);
    cnt_raddr = BW'(idx);
    pfx_we    = 1'b0;
    pfx_waddr = '0;
    pfx_wdata = '0;
    cur_we    = 1'b0;
    cur_waddr = off_r;
    cur_wdata = cur_rd + RW'(1);
    srt_we    = (cmd.op == OP_SC_WR) && rng_r && pos_ok;
    unique case (cmd.op)
      OP_CLR: begin
        cnt_we    = 1'b1;
        cnt_waddr = BW'(idx);
        cnt_wdata = '0;
      end
      OP_LOAD:  cnt_raddr = key_off;
      OP_LD_WR: cnt_we = 1'b1;
      OP_PFX_INIT: pfx_we = 1'b1;
      OP_PFX_WR: begin
        pfx_we    = 1'b1;
        pfx_waddr = idx + PW'(1);
        pfx_wdata = acc + cnt_rd;
        cur_we    = 1'b1;
        cur_waddr = BW'(idx);
        cur_wdata = RW'(acc);
      end
      OP_SC_WR: cur_we = rng_r;
      default: ;
    endcase
  end

  csbi_ram #(.WIDTH(KEY_W), .DEPTH(MAX_ITEMS)) u_key_ram (
    .clk(clk), .we(key_we), .waddr(key_waddr), .wdata(key_r),
    .raddr(IW'(j)), .rdata(key_rd)
  );

  csbi_ram #(.WIDTH(CW), .DEPTH(MAX_BUCKETS)) u_cnt_ram (
    .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
    .raddr(cnt_raddr), .rdata(cnt_rd)
  );

  csbi_ram #(.WIDTH(CW), .DEPTH(MAX_BUCKETS + 1)) u_pfx_ram (
    .clk(clk), .we(pfx_we), .waddr(pfx_waddr), .wdata(pfx_wdata),
    .raddr(PW'(addr_r)), .rdata(pfx_rd)
  );

  csbi_ram #(.WIDTH(RW), .DEPTH(MAX_BUCKETS)) u_cur_ram (
    .clk(clk), .we(cur_we), .waddr(cur_waddr), .wdata(cur_wdata),
    .raddr(sc_off), .rdata(cur_rd)
  );

  csbi_ram #(.WIDTH(IW), .DEPTH(MAX_ITEMS)) u_srt_ram (
    .clk(clk), .we(srt_we), .waddr(IW'(cur_rd)), .wdata(IW'(j)),
    .raddr(IW'(addr_r)), .rdata(srt_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      key_min       <= '0;
      key_max       <= KEY_W'(255);
      item_count    <= '0;
      built         <= 1'b0;
      idx           <= '0;
      clear_pending <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_KEY_MIN: key_min <= cfg_data;
          REG_KEY_MAX: key_max <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready && (cmd.op != OP_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (cmd.op)
        OP_ACCEPT: begin
          if (in_valid) begin
            cmd_r  <= in_command;
            key_r  <= in_key;
            last_r <= in_last;
            addr_r <= in_address;
          end
        end
        OP_CLR: begin
          if (stat.clr_done) begin
            idx           <= '0;
            clear_pending <= 1'b0;
          end else begin
            idx <= idx + PW'(1);
          end
        end
        OP_LOAD: begin
          res_value <= '0;
          off_r     <= key_off;
          if (built) begin
            built <= 1'b0;
          end
          priority if (range_wide) begin
            res_status <= ST_RANGE_WIDE;
            if (last_r) begin
              clear_pending <= 1'b1;
            end
            item_count <= last_r ? '0 : ic_eff;
          end else if (!ld_store) begin
            res_status <= ST_OVERFLOW;
          end else begin
            res_status <= ST_OK;
            item_count <= ic_eff + CW'(1);
          end
        end
        OP_READ: begin
          rd_ok_r    <= rd_ok;
          res_status <= rd_ok ? ST_OK : ST_BAD_ADDR;
        end
        OP_RD_CAP: begin
          if (!rd_ok_r) begin
            res_value <= '0;
          end else if (cmd_r == CMD_RD_PREFIX) begin
            res_value <= VAL_W'(pfx_rd);
          end else begin
            res_value <= VAL_W'(srt_rd);
          end
        end
        OP_PFX_INIT: begin
          idx           <= '0;
          acc           <= '0;
          j             <= '0;
          built_buckets <= n_cur;
        end
        OP_PFX_WR: begin
          acc <= acc + cnt_rd;
          idx <= idx + PW'(1);
        end
        OP_SC_RDK: begin
          if (stat.scat_done) begin
            built         <= 1'b1;
            total         <= acc;
            res_value     <= VAL_W'(acc);
            clear_pending <= 1'b1;
          end
        end
        OP_SC_RDC: begin
          rng_r <= sc_in_rng;
          off_r <= sc_off;
        end
        OP_SC_WR: j <= j + CW'(1);
        OP_DONE: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            out_value  <= res_value;
            out_status <= res_status;
            idx        <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  a_item_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(item_count) <= MAX_ITEMS)
    else $error("item count beyond capacity");

  a_rmw_order: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_LD_WR) |-> ($past(cmd.op) == OP_LOAD))
    else $error("bucket count write without preceding read");

  a_build_end: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_SC_RDK && stat.scat_done) |=> (built && clear_pending))
    else $error("build finished without marking index built");

endmodule
